>>> rtl/gmps_pkg.sv
// Shared constants, types and arithmetic helpers for the grid minimum path sum block.
package gmps_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COST_W  = 16;
  localparam int SUM_W   = 32;
  localparam int COUNT_W = 11;
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int INDEX_W = 2;

  localparam logic [INDEX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [INDEX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic [COUNT_W-1:0] MAX_ROWS_CNT = COUNT_W'(MAX_ROWS);
  localparam logic [COUNT_W-1:0] MAX_COLS_CNT = COUNT_W'(MAX_COLS);

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [SUM_W:0]   wide_sum_t;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] maxv);
    logic [COUNT_W-1:0] r;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic sum_t sat_sum(input wide_sum_t v);
    sum_t r;
    if (v[SUM_W] != v[SUM_W-1]) begin
      r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/gmps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/grid_min_path_sum.sv
// Grid minimum right/down path sum over a raster-order cell stream, one row buffer in RAM.
// An input transfer enters stage s1, which uses its row buffer read, then the output register.
// Throughput: one cell per cycle when not stalled; the row buffer read is issued at transfer.
// Reset: row and column counts go to 1, position and left sum to 0, no results pending.
// The row buffer is not cleared; an entry is only used after the row above has written it.
module grid_min_path_sum
  import gmps_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [INDEX_W-1:0]         cfg_index,
  input  logic [COUNT_W-1:0]         cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COST_W-1:0]   cell_cost,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SUM_W-1:0]    path_cost,
  output logic                       is_last
);

  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] col_count;
  logic [ROW_W-1:0]   row_index;
  logic [COL_W-1:0]   col_index;
  logic [ROW_W-1:0]   row_index_next;
  logic [COL_W-1:0]   col_index_next;
  sum_t               left_sum;

  logic                     s1_valid;
  logic signed [COST_W-1:0] s1_cost;
  logic [COL_W-1:0]         s1_col;
  logic                     s1_top;
  logic                     s1_left;
  logic                     s1_last;
  logic                     s1_fwd;
  sum_t                     s1_fwd_sum;

  logic       accept;
  logic       advance;
  logic       col_wrap;
  logic       row_wrap;
  logic       cell_last;
  logic [SUM_W-1:0] ram_rdata;
  sum_t       up_sum;
  sum_t       best;
  wide_sum_t  raw_sum;
  sum_t       cell_sum;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign col_wrap  = ({1'b0, col_index} + COUNT_W'(1)) >= col_count;
  assign row_wrap  = ({1'b0, row_index} + COUNT_W'(1)) >= row_count;
  assign cell_last = col_wrap && row_wrap;

  always_comb begin
    col_index_next = col_index + COL_W'(1);
    row_index_next = row_index;
    if (col_wrap) begin
      col_index_next = '0;
      row_index_next = row_wrap ? '0 : row_index + ROW_W'(1);
    end
  end

  gmps_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLS)
  ) u_row_sums (
    .clk   (clk),
    .we    (advance),
    .waddr (s1_col),
    .wdata (cell_sum),
    .re    (accept),
    .raddr (col_index),
    .rdata (ram_rdata)
  );

  always_comb begin
    up_sum = s1_fwd ? s1_fwd_sum : sum_t'(ram_rdata);
    best   = (up_sum < left_sum) ? up_sum : left_sum;
    if (s1_top && s1_left) begin
      raw_sum = wide_sum_t'(s1_cost);
    end else if (s1_top) begin
      raw_sum = wide_sum_t'(s1_cost) + wide_sum_t'(left_sum);
    end else if (s1_left) begin
      raw_sum = wide_sum_t'(s1_cost) + wide_sum_t'(up_sum);
    end else begin
      raw_sum = wide_sum_t'(s1_cost) + wide_sum_t'(best);
    end
    cell_sum = sat_sum(raw_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= COUNT_W'(1);
      col_count <= COUNT_W'(1);
      row_index <= '0;
      col_index <= '0;
      left_sum  <= '0;
      s1_valid  <= 1'b0;
      s1_fwd    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_COUNT: begin
            row_count <= clamp_count(cfg_data, MAX_ROWS_CNT);
            row_index <= '0;
            col_index <= '0;
          end
          REG_COL_COUNT: begin
            col_count <= clamp_count(cfg_data, MAX_COLS_CNT);
            row_index <= '0;
            col_index <= '0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        row_index <= row_index_next;
        col_index <= col_index_next;
      end

      if (accept) begin
        s1_valid <= 1'b1;
        s1_fwd   <= advance && (s1_col == col_index);
      end else if (advance) begin
        s1_valid <= 1'b0;
        s1_fwd   <= 1'b0;
      end

      if (advance) begin
        left_sum  <= cell_sum;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost    <= cell_cost;
      s1_col     <= col_index;
      s1_top     <= (row_index == '0);
      s1_left    <= (col_index == '0);
      s1_last    <= cell_last;
      s1_fwd_sum <= cell_sum;
    end
    if (advance) begin
      path_cost <= cell_sum;
      is_last   <= s1_last;
    end
  end

endmodule

>>> tb/grid_min_path_sum_checker.sv
// Checker for grid_min_path_sum: predicts each cell's path sum from observed transfers and compares.
module grid_min_path_sum_checker
  import gmps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [INDEX_W-1:0]       cfg_index,
  input  logic [COUNT_W-1:0]       cfg_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [COST_W-1:0] cell_cost,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [SUM_W-1:0]  path_cost,
  input  logic                     is_last,
  output int                       fail_count,
  output int                       pending
);

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  typedef struct packed {
    sum_t path;
    logic corner;
  } path_result_t;

  path_result_t expected_paths[$];
  sum_t         best_row[MAX_COLS];
  sum_t         left_best;
  int unsigned  rows_used;
  int unsigned  cols_used;
  int unsigned  cur_row;
  int unsigned  cur_col;
  int           errors = 0;

  function automatic int unsigned limit_count(input logic [COUNT_W-1:0] v,
                                              input int unsigned ceiling);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > ceiling) begin
      return ceiling;
    end
    return int'(v);
  endfunction

  function automatic path_result_t advance_path(input logic signed [COST_W-1:0] cost);
    longint       total;
    longint       up;
    longint       lf;
    path_result_t r;
    up = best_row[cur_col];
    lf = left_best;
    if (cur_row == 0 && cur_col == 0) begin
      total = cost;
    end else if (cur_row == 0) begin
      total = cost + lf;
    end else if (cur_col == 0) begin
      total = cost + up;
    end else begin
      total = cost + ((up < lf) ? up : lf);
    end
    if (total > SUM_HI) begin
      total = SUM_HI;
    end else if (total < SUM_LO) begin
      total = SUM_LO;
    end
    r.path = sum_t'(total);
    r.corner = (cur_row + 1 >= rows_used) && (cur_col + 1 >= cols_used);
    best_row[cur_col] = r.path;
    left_best = r.path;
    cur_col++;
    if (cur_col >= cols_used) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= rows_used) begin
        cur_row = 0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    path_result_t want;
    if (rst) begin
      expected_paths.delete();
      rows_used = 1;
      cols_used = 1;
      cur_row = 0;
      cur_col = 0;
      left_best = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_paths.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: path_cost %0d is_last %0b", path_cost, is_last);
          end
        end else begin
          want = expected_paths.pop_front();
          if (path_cost !== want.path || is_last !== want.corner) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: path_cost expected %0d got %0d, is_last expected %0b got %0b",
                       want.path, path_cost, want.corner, is_last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_paths.push_back(advance_path(cell_cost));
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ROW_COUNT: begin
            rows_used = limit_count(cfg_data, MAX_ROWS);
            cur_row = 0;
            cur_col = 0;
          end
          REG_COL_COUNT: begin
            cols_used = limit_count(cfg_data, MAX_COLS);
            cur_row = 0;
            cur_col = 0;
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= errors;
    pending <= expected_paths.size();
  end

endmodule

>>> tb/grid_min_path_sum_tb.sv
// Top of the grid_min_path_sum testbench: clock, reset, grid configuration, cell stimulus, result stalls and verdict.
module grid_min_path_sum_tb
  import gmps_pkg::*;
();

  typedef logic signed [COST_W-1:0] cost_t;

  localparam logic [INDEX_W-1:0] REG_SPARE0 = 2'd2;
  localparam logic [INDEX_W-1:0] REG_SPARE1 = 2'd3;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [INDEX_W-1:0]       cfg_index;
  logic [COUNT_W-1:0]       cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [COST_W-1:0] cell_cost;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [SUM_W-1:0]  path_cost;
  logic                     is_last;
  int                       fail_count;
  int                       pending;
  int                       cells_sent = 0;
  bit                       quiet = 0;

  grid_min_path_sum dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cell_cost(cell_cost),
    .out_valid(out_valid), .out_stall(out_stall), .path_cost(path_cost), .is_last(is_last)
  );

  grid_min_path_sum_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .cell_cost(cell_cost),
    .out_valid(out_valid), .out_stall(out_stall), .path_cost(path_cost), .is_last(is_last),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("grid_min_path_sum verification failed");
    $finish;
  end

  initial begin
    int gap;
    out_stall <= 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 11);
      out_stall <= (gap != 0);
      repeat (gap) @(posedge clk);
      if (gap != 0) begin
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic cost_t pick_cost();
    case ($urandom_range(0, 7))
      0: return cost_t'(16'h7fff);
      1: return cost_t'(16'h8000);
      2: return cost_t'($signed($urandom_range(0, 32)) - 16);
      default: return cost_t'($urandom());
    endcase
  endfunction

  task automatic send_cell(input cost_t cost);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_cost <= cost;
    do @(posedge clk); while (in_stall);
    cells_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(input logic [COUNT_W-1:0] rows, input logic [COUNT_W-1:0] cols);
    settle();
    if ($urandom_range(0, 1) != 0) begin
      write_reg(REG_ROW_COUNT, rows);
      write_reg(REG_COL_COUNT, cols);
    end else begin
      write_reg(REG_COL_COUNT, cols);
      write_reg(REG_ROW_COUNT, rows);
    end
  endtask

  initial begin
    int rows;
    int cols;
    int area;
    int cells;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cell_cost <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-cell grids straight out of reset
    send_cell(cost_t'(16'h7fff));
    send_cell(cost_t'(16'h8000));
    send_cell(cost_t'(0));

    set_grid(11'd2, 11'd3);
    send_cell(cost_t'(5));
    send_cell(cost_t'(-3));
    send_cell(cost_t'(8));
    send_cell(cost_t'(16'h8000));
    send_cell(cost_t'(16'h7fff));
    send_cell(cost_t'(-1));
    // spare register writes mid-grid must not move the position
    send_cell(cost_t'(1));
    send_cell(cost_t'(-2));
    settle();
    write_reg(REG_SPARE0, 11'h7ff);
    write_reg(REG_SPARE1, 11'h000);
    send_cell(cost_t'(1));
    send_cell(cost_t'(100));
    send_cell(cost_t'(16'h5555));
    send_cell(cost_t'(16'haaaa));

    set_grid(11'd0, 11'd0);
    send_cell(pick_cost());
    send_cell(pick_cost());

    set_grid(11'h7ff, 11'd1);
    repeat (40) send_cell(pick_cost());

    quiet = 1;
    set_grid(11'd2, 11'h7ff);
    repeat (1100) send_cell(pick_cost());
    quiet = 0;

    while (cells_sent < 2000) begin
      case ($urandom_range(0, 9))
        0: rows = 0;
        1: rows = $urandom_range(9, 40);
        default: rows = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0: cols = 0;
        1: cols = $urandom_range(9, 40);
        default: cols = $urandom_range(1, 8);
      endcase
      area = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
      if ($urandom_range(0, 3) == 0) begin
        cells = $urandom_range(1, 2 * area + 3);
      end else begin
        cells = area * $urandom_range(1, 3);
      end
      set_grid(COUNT_W'(rows), COUNT_W'(cols));
      quiet = ($urandom_range(0, 3) == 0);
      repeat (cells / 2) send_cell(pick_cost());
      if ($urandom_range(0, 4) == 0) begin
        settle();
        write_reg($urandom_range(0, 1) != 0 ? REG_SPARE0 : REG_SPARE1,
                  COUNT_W'($urandom()));
      end
      repeat (cells - cells / 2) send_cell(pick_cost());
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("grid_min_path_sum verification clean");
    end else begin
      $display("grid_min_path_sum verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/gmps_pkg.sv
rtl/gmps_ram.sv
rtl/grid_min_path_sum.sv
tb/grid_min_path_sum_checker.sv
tb/grid_min_path_sum_tb.sv
